FILE: src/gdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared constants, types and calendar tables for the day difference pipe.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 7;
  localparam int DayW   = 7;
  localparam int CountW = 23;
  localparam int DiffW  = 23;
  localparam int QuotW  = 8;   // year / 100 fits in 8 bits for 14-bit years
  localparam int DbmW   = 9;   // days before month, max 334
  localparam int MpartW = 9;   // days before month plus day, max 461

  // x / 100 == (x * Recip100) >> Shift100 for every 14-bit x
  localparam int Recip100  = 5243;
  localparam int RecipW    = 13;
  localparam int Shift100  = 19;
  localparam int ProdW     = YearW + RecipW;

  localparam logic [MonthW-1:0] MonthJan = 7'd1;
  localparam logic [MonthW-1:0] MonthFeb = 7'd2;
  localparam logic [MonthW-1:0] MonthDec = 7'd12;

  localparam logic [8:0] DaysPerYear = 9'd365;
  localparam logic [6:0] Hundred     = 7'd100;

  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [CountW-1:0] count_t;

  // per-stage advance strobes of the pipe
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } pipe_ctrl_t;

  function automatic logic [DbmW-1:0] days_before(input month_t m);
    logic [DbmW-1:0] r;
    unique case (m)
      7'd1:    r = 9'd0;
      7'd2:    r = 9'd31;
      7'd3:    r = 9'd59;
      7'd4:    r = 9'd90;
      7'd5:    r = 9'd120;
      7'd6:    r = 9'd151;
      7'd7:    r = 9'd181;
      7'd8:    r = 9'd212;
      7'd9:    r = 9'd243;
      7'd10:   r = 9'd273;
      7'd11:   r = 9'd304;
      7'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input month_t m, input logic leap);
    logic [4:0] r;
    unique case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
      7'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/gdd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_ctrl
// Valid bits and stall logic of the four-stage pipe.
// ----------------------------------------------------------------------------
module gdd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output gdd_pkg::pipe_ctrl_t     ctrl
);

  logic v1_r, v2_r, v3_r, v4_r;

  // a stage moves when it is empty or the next stage moves
  always_comb begin
    ctrl.s4_en = !v4_r || out_tready;
    ctrl.s3_en = !v3_r || ctrl.s4_en;
    ctrl.s2_en = !v2_r || ctrl.s3_en;
    ctrl.s1_en = !v1_r || ctrl.s2_en;
  end

  assign in_tready  = ctrl.s1_en;
  assign out_tvalid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ctrl.s1_en) v1_r <= in_tvalid;
      if (ctrl.s2_en) v2_r <= v1_r;
      if (ctrl.s3_en) v3_r <= v2_r;
      if (ctrl.s4_en) v4_r <= v3_r;
    end
  end

endmodule
`default_nettype wire

FILE: src/gdd_date_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_date_count
// Three-stage check and day count of one date.
// ----------------------------------------------------------------------------
module gdd_date_count (
  input  wire logic               clk,
  input  wire gdd_pkg::pipe_ctrl_t ctrl,
  input  wire gdd_pkg::year_t     year,
  input  wire gdd_pkg::month_t    month,
  input  wire gdd_pkg::day_t      day,
  output gdd_pkg::count_t         count_r,
  output logic                    valid_r
);

  // stage 1: reciprocal multiplies for year / 100 and (year - 1) / 100
  logic [gdd_pkg::ProdW-1:0]  prod_y, prod_n;
  gdd_pkg::year_t             n_in;
  gdd_pkg::year_t             y1_r, n1_r;
  gdd_pkg::month_t            m1_r;
  gdd_pkg::day_t              d1_r;
  logic [gdd_pkg::QuotW-1:0]  qy1_r, qn1_r;

  // year 0 adds no whole years
  assign n_in   = (year == '0) ? '0 : year - gdd_pkg::YearW'(1);
  assign prod_y = gdd_pkg::ProdW'(year) *
                  gdd_pkg::ProdW'(gdd_pkg::Recip100);
  assign prod_n = gdd_pkg::ProdW'(n_in) *
                  gdd_pkg::ProdW'(gdd_pkg::Recip100);

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      y1_r  <= year;
      n1_r  <= n_in;
      m1_r  <= month;
      d1_r  <= day;
      qy1_r <= prod_y[gdd_pkg::Shift100 +: gdd_pkg::QuotW];
      qn1_r <= prod_n[gdd_pkg::Shift100 +: gdd_pkg::QuotW];
    end
  end

  // stage 2: leap rule, validity, whole years and month part
  logic [13:0]                  hund;
  logic [6:0]                   rem100;
  logic                         leap;
  logic [4:0]                   mlen;
  logic                         ok;
  logic [gdd_pkg::CountW-1:0]   n_ext, ypart;
  logic [gdd_pkg::MpartW-1:0]   mpart;
  logic [gdd_pkg::CountW-1:0]   ypart2_r;
  logic [gdd_pkg::MpartW-1:0]   mpart2_r;
  logic                         extra2_r;
  logic                         ok2_r;

  assign hund   = 14'(qy1_r) * 14'(gdd_pkg::Hundred);
  assign rem100 = 7'(y1_r - hund);
  // divisible by 400 is divisible by 100 with a quotient divisible by 4
  assign leap   = ((y1_r[1:0] == 2'b00) && (rem100 != 7'd0)) ||
                  ((rem100 == 7'd0) && (qy1_r[1:0] == 2'b00));
  assign mlen   = gdd_pkg::month_len(m1_r, leap);
  assign ok     = (m1_r >= gdd_pkg::MonthJan) && (m1_r <= gdd_pkg::MonthDec) &&
                  (d1_r != '0) && (d1_r <= gdd_pkg::DayW'(mlen));
  assign n_ext  = gdd_pkg::CountW'(n1_r);
  assign ypart  = n_ext * gdd_pkg::CountW'(gdd_pkg::DaysPerYear)
                + (n_ext >> 2)
                - gdd_pkg::CountW'(qn1_r)
                + gdd_pkg::CountW'(qn1_r >> 2);
  assign mpart  = gdd_pkg::days_before(m1_r) + gdd_pkg::MpartW'(d1_r);

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      ypart2_r <= ypart;
      mpart2_r <= mpart;
      extra2_r <= leap && (m1_r > gdd_pkg::MonthFeb);
      ok2_r    <= ok;
    end
  end

  // stage 3: final day count
  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      count_r <= ypart2_r + gdd_pkg::CountW'(mpart2_r)
               + gdd_pkg::CountW'(extra2_r);
      valid_r <= ok2_r;
    end
  end

endmodule
`default_nettype wire

FILE: src/gdd_diff.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_diff
// Output stage: subtracts the two day counts, saturates and registers.
// ----------------------------------------------------------------------------
module gdd_diff (
  input  wire logic               clk,
  input  wire gdd_pkg::pipe_ctrl_t ctrl,
  input  wire gdd_pkg::count_t    first_count,
  input  wire logic               first_ok,
  input  wire gdd_pkg::count_t    second_count,
  input  wire logic               second_ok,
  output logic                    first_valid_r,
  output logic                    second_valid_r,
  output logic [gdd_pkg::DiffW-1:0] day_difference_r
);

  localparam int WideW = gdd_pkg::CountW + 1;

  logic signed [WideW-1:0]         wide;
  logic [gdd_pkg::DiffW-1:0]       sat;

  assign wide = signed'({1'b0, second_count}) - signed'({1'b0, first_count});

  // out of range only for years above 9999
  always_comb begin
    if (wide[WideW-1] != wide[WideW-2]) begin
      sat = wide[WideW-1] ? {1'b1, {(gdd_pkg::DiffW-1){1'b0}}}
                          : {1'b0, {(gdd_pkg::DiffW-1){1'b1}}};
    end else begin
      sat = wide[gdd_pkg::DiffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s4_en) begin
      first_valid_r    <= first_ok;
      second_valid_r   <= second_ok;
      day_difference_r <= (first_ok && second_ok) ? sat : '0;
    end
  end

endmodule
`default_nettype wire

FILE: src/gregorian_day_difference.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_day_difference
// Validity check and signed day difference of two Gregorian dates.
// ----------------------------------------------------------------------------
// Takes a pair of proleptic Gregorian dates per item and returns both validity
// flags and the day difference, second date minus first (0 when either date
// is invalid, saturated to 23 bits for years above 9999). The pipe is four
// register stages deep: reciprocal multiply for the divisions by 100, leap
// rule and year sum, day count, then subtract into the output register. A new
// item is accepted every cycle while in_tready is high; out_tvalid rises when
// the item enters the output register. A stall on the output side holds the
// full stages in place while empty stages keep filling, so in_tready drops
// only once all four stages hold an item.
module gregorian_day_difference (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // first_year[13:0], first_month[20:14], first_day[27:21],
  // second_year[41:28], second_month[48:42], second_day[55:49]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // first_valid[0], second_valid[1], day_difference[24:2], zero fill [31:25]
  output logic [31:0]      out_tdata
);

  gdd_pkg::pipe_ctrl_t ctrl;
  gdd_pkg::count_t     first_count, second_count;
  logic                first_ok, second_ok;
  logic                first_valid_r, second_valid_r;
  logic [gdd_pkg::DiffW-1:0] day_difference_r;

  gdd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  gdd_date_count u_first (
    .clk     (clk),
    .ctrl    (ctrl),
    .year    (in_tdata[13:0]),
    .month   (in_tdata[20:14]),
    .day     (in_tdata[27:21]),
    .count_r (first_count),
    .valid_r (first_ok)
  );

  gdd_date_count u_second (
    .clk     (clk),
    .ctrl    (ctrl),
    .year    (in_tdata[41:28]),
    .month   (in_tdata[48:42]),
    .day     (in_tdata[55:49]),
    .count_r (second_count),
    .valid_r (second_ok)
  );

  gdd_diff u_diff (
    .clk              (clk),
    .ctrl             (ctrl),
    .first_count      (first_count),
    .first_ok         (first_ok),
    .second_count     (second_count),
    .second_ok        (second_ok),
    .first_valid_r    (first_valid_r),
    .second_valid_r   (second_valid_r),
    .day_difference_r (day_difference_r)
  );

  assign out_tdata = {7'b0, day_difference_r, second_valid_r, first_valid_r};

endmodule
`default_nettype wire
